### rtl/core/adc_average_distance_linearizer_macros.svh
// ============================================================================
// adc_average_distance_linearizer_macros.svh
// Assertion macros used by the checker of the distance linearizer.
// ============================================================================
`ifndef ADC_AVERAGE_DISTANCE_LINEARIZER_MACROS_SVH
`define ADC_AVERAGE_DISTANCE_LINEARIZER_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define ADL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define ADL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/adl_pkg.sv
// ============================================================================
// adl_pkg
// Constants, segment table and shared types of the distance linearizer.
// ============================================================================
package adl_pkg;

    // Window and field widths
    localparam int SAMPLES  = 20;
    localparam int SAMPLE_W = 10;
    localparam int SUM_W    = 15;
    localparam int CNT_W    = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int MEAN_W   = 10;
    localparam int DIST_W   = 7;
    localparam int SEG_W    = 3;
    localparam int NUM_W    = 15;
    localparam int WIDE_W   = 17;
    localparam int PROD_W   = 32;
    localparam int RECIP_W  = 17;

    // Mean by reciprocal: exact floor for any sum below 2**SUM_W
    localparam int MEAN_SH  = SUM_W + $clog2(SAMPLES);
    localparam int MEAN_M   = ((1 << MEAN_SH) + SAMPLES - 1) / SAMPLES;

    // Knots and end distances
    localparam logic [MEAN_W-1:0] LOW_KNOT = MEAN_W'(80);
    localparam logic [MEAN_W-1:0] TOP_KNOT = MEAN_W'(490);
    localparam logic [DIST_W-1:0] LOW_DIST = DIST_W'(80);
    localparam logic [DIST_W-1:0] TOP_DIST = DIST_W'(10);

    // Segment that halves instead of dividing by a slope
    localparam logic [SEG_W-1:0] SEG_HALF = SEG_W'(2);

    // Slopes in hundredths and their reciprocals
    localparam int K0 = 77;
    localparam int K1 = 211;
    localparam int K3 = 288;
    localparam int K4 = 511;
    localparam int K5 = 888;
    localparam int K6 = 2377;
    localparam int SH0 = NUM_W + $clog2(K0);
    localparam int SH1 = NUM_W + $clog2(K1);
    localparam int SH3 = NUM_W + $clog2(K3);
    localparam int SH4 = NUM_W + $clog2(K4);
    localparam int SH5 = NUM_W + $clog2(K5);
    localparam int SH6 = NUM_W + $clog2(K6);
    localparam int M0 = ((1 << SH0) + K0 - 1) / K0;
    localparam int M1 = ((1 << SH1) + K1 - 1) / K1;
    localparam int M3 = ((1 << SH3) + K3 - 1) / K3;
    localparam int M4 = ((1 << SH4) + K4 - 1) / K4;
    localparam int M5 = ((1 << SH5) + K5 - 1) / K5;
    localparam int M6 = ((1 << SH6) + K6 - 1) / K6;

    // Window handed from the accumulator to the mean stage
    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] sum;
    } win_t;

    function automatic logic [SEG_W-1:0] seg_of(input logic [MEAN_W-1:0] mean);
        logic [SEG_W-1:0] s;
        priority if (mean >= MEAN_W'(276)) s = SEG_W'(6);
        else if (mean >= MEAN_W'(196))     s = SEG_W'(5);
        else if (mean >= MEAN_W'(150))     s = SEG_W'(4);
        else if (mean >= MEAN_W'(124))     s = SEG_W'(3);
        else if (mean >= MEAN_W'(106))     s = SEG_W'(2);
        else if (mean >= MEAN_W'(87))      s = SEG_W'(1);
        else                               s = SEG_W'(0);
        return s;
    endfunction

    function automatic logic [MEAN_W-1:0] seg_lo(input logic [SEG_W-1:0] s);
        logic [MEAN_W-1:0] v;
        unique case (s)
            SEG_W'(0): v = MEAN_W'(80);
            SEG_W'(1): v = MEAN_W'(87);
            SEG_W'(2): v = MEAN_W'(106);
            SEG_W'(3): v = MEAN_W'(124);
            SEG_W'(4): v = MEAN_W'(150);
            SEG_W'(5): v = MEAN_W'(196);
            default:   v = MEAN_W'(276);
        endcase
        return v;
    endfunction

    function automatic logic [DIST_W-1:0] seg_base(input logic [SEG_W-1:0] s);
        logic [DIST_W-1:0] v;
        unique case (s)
            SEG_W'(0): v = DIST_W'(80);
            SEG_W'(1): v = DIST_W'(70);
            SEG_W'(2): v = DIST_W'(60);
            SEG_W'(3): v = DIST_W'(50);
            SEG_W'(4): v = DIST_W'(40);
            SEG_W'(5): v = DIST_W'(30);
            default:   v = DIST_W'(20);
        endcase
        return v;
    endfunction

    // Slope minus one, the bias that turns the floor quotient into a ceiling
    function automatic logic [WIDE_W-1:0] seg_bias(input logic [SEG_W-1:0] s);
        logic [WIDE_W-1:0] v;
        unique case (s)
            SEG_W'(0): v = WIDE_W'(K0 - 1);
            SEG_W'(1): v = WIDE_W'(K1 - 1);
            SEG_W'(3): v = WIDE_W'(K3 - 1);
            SEG_W'(4): v = WIDE_W'(K4 - 1);
            SEG_W'(5): v = WIDE_W'(K5 - 1);
            default:   v = WIDE_W'(K6 - 1);
        endcase
        return v;
    endfunction

    function automatic logic [RECIP_W-1:0] seg_recip(input logic [SEG_W-1:0] s);
        logic [RECIP_W-1:0] v;
        unique case (s)
            SEG_W'(0): v = RECIP_W'(M0);
            SEG_W'(1): v = RECIP_W'(M1);
            SEG_W'(3): v = RECIP_W'(M3);
            SEG_W'(4): v = RECIP_W'(M4);
            SEG_W'(5): v = RECIP_W'(M5);
            default:   v = RECIP_W'(M6);
        endcase
        return v;
    endfunction

    function automatic logic [DIST_W-1:0] seg_quot(input logic [PROD_W-1:0] prod,
                                                   input logic [SEG_W-1:0]  s);
        logic [PROD_W-1:0] q;
        unique case (s)
            SEG_W'(0): q = prod >> SH0;
            SEG_W'(1): q = prod >> SH1;
            SEG_W'(3): q = prod >> SH3;
            SEG_W'(4): q = prod >> SH4;
            SEG_W'(5): q = prod >> SH5;
            default:   q = prod >> SH6;
        endcase
        return q[DIST_W-1:0];
    endfunction

endpackage

### rtl/core/adl_accum.sv
// ============================================================================
// adl_accum
// Sample accumulator: sums a window of samples and hands the total onward.
// ============================================================================
module adl_accum
    import adl_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic                win_ready,
    output win_t                win
);

    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             win_valid_reg, win_valid_next;
    logic [SUM_W-1:0] win_sum_reg;
    logic [SUM_W-1:0] sum_total;
    logic             accept;
    logic             last;

    assign s_tready  = !win_valid_reg || win_ready;
    assign accept    = s_tvalid && s_tready;
    assign sum_total = sum_reg + SUM_W'(sample);
    assign last      = (cnt_reg == CNT_W'(SAMPLES - 1));

    always_comb begin
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        win_valid_next = win_valid_reg && !win_ready;
        if (accept) begin
            if (last) begin
                sum_next       = '0;
                cnt_next       = '0;
                win_valid_next = 1'b1;
            end else begin
                sum_next = sum_total;
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= '0;
            cnt_reg       <= '0;
            win_valid_reg <= 1'b0;
        end else begin
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            win_valid_reg <= win_valid_next;
        end
    end

    // Capture the closing total
    always_ff @(posedge aclk) begin
        if (accept && last) begin
            win_sum_reg <= sum_total;
        end
    end

    assign win.valid = win_valid_reg;
    assign win.sum   = win_sum_reg;

endmodule

### rtl/core/adc_average_distance_linearizer.sv
// A window's total is registered in the accumulator by the edge that accepts its last sample,
// then moves through the mean, segment, quotient and output registers to m_tvalid.
// Throughput: one sample per cycle while s_tready is high; one result per SAMPLES samples.
// Five register stages (accumulate, mean, segment, quotient, output) each advance
// when the next one is free, so s_tready drops only when all of them are full.
// Reset (aresetn low, synchronous): clear sum, count, last distance and all valids.
// ============================================================================
// adc_average_distance_linearizer
// Averages a window of converter samples and maps the mean to a distance in
// centimeters through a seven-segment piecewise linear table.
// ============================================================================
module adc_average_distance_linearizer
    import adl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] adc_sample, [15:10] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [6:0] distance_cm, [16:7] mean_value, [23:17] zero
    output logic [0:0]  m_tuser    // [0] held
);

    // Segment stage payload
    typedef struct packed {
        logic              low;
        logic              top;
        logic              over;
        logic [SEG_W-1:0]  seg;
        logic [NUM_W-1:0]  num;
        logic [MEAN_W-1:0] mean;
    } seg_stage_t;

    // Quotient stage payload
    typedef struct packed {
        logic              low;
        logic              top;
        logic              over;
        logic [SEG_W-1:0]  seg;
        logic [DIST_W-1:0] quot;
        logic [MEAN_W-1:0] mean;
    } quot_stage_t;

    win_t              win;
    logic              en_out, en4, en3, en2;

    logic              v2_reg, v3_reg, v4_reg, m_valid_reg;
    logic [MEAN_W-1:0] mean_reg;
    seg_stage_t        s3_reg, s3_next;
    quot_stage_t       s4_reg, s4_next;
    logic [DIST_W-1:0] last_dist_reg, last_dist_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic [MEAN_W-1:0] mean_out_reg;
    logic              held_reg;

    logic [PROD_W-1:0] mean_prod;
    logic [MEAN_W-1:0] seg_d;
    logic [WIDE_W-1:0] num_wide;
    logic [PROD_W-1:0] quot_prod;
    logic [DIST_W-1:0] lin_dist;

    // Stall chain: a stage loads when empty or when its successor loads
    assign en_out = !m_valid_reg || m_tready;
    assign en4    = !v4_reg || en_out;
    assign en3    = !v3_reg || en4;
    assign en2    = !v2_reg || en3;

    adl_accum u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .sample    (s_tdata[SAMPLE_W-1:0]),
        .win_ready (en2),
        .win       (win)
    );

    // Mean: multiply by the window reciprocal, keep the integer part
    assign mean_prod = PROD_W'(win.sum) * PROD_W'(MEAN_M);

    // Segment: locate the knot, form the biased numerator 100*d + K - 1, or d alone in the halving segment
    always_comb begin
        s3_next.low  = (mean_reg <= LOW_KNOT);
        s3_next.top  = (mean_reg == TOP_KNOT);
        s3_next.over = (mean_reg > TOP_KNOT);
        s3_next.seg  = seg_of(mean_reg);
        s3_next.mean = mean_reg;
        seg_d        = mean_reg - seg_lo(s3_next.seg);
        num_wide     = WIDE_W'(seg_d) * WIDE_W'(100) + seg_bias(s3_next.seg);
        if (s3_next.seg == SEG_HALF) begin
            s3_next.num = NUM_W'(seg_d);
        end else begin
            s3_next.num = num_wide[NUM_W-1:0];
        end
    end

    // Quotient: ceiling of 100*d/K by reciprocal, or a halving
    assign quot_prod = PROD_W'(s3_reg.num) * PROD_W'(seg_recip(s3_reg.seg));

    always_comb begin
        s4_next.low  = s3_reg.low;
        s4_next.top  = s3_reg.top;
        s4_next.over = s3_reg.over;
        s4_next.seg  = s3_reg.seg;
        s4_next.mean = s3_reg.mean;
        if (s3_reg.seg == SEG_HALF) begin
            s4_next.quot = s3_reg.num[DIST_W:1];
        end else begin
            s4_next.quot = seg_quot(quot_prod, s3_reg.seg);
        end
    end

    // Output: pick an end value or the segment's linear value, or hold the last distance past the top knot
    always_comb begin
        priority if (s4_reg.low) lin_dist = LOW_DIST;
        else if (s4_reg.top)     lin_dist = TOP_DIST;
        else                     lin_dist = seg_base(s4_reg.seg) - s4_reg.quot;

        last_dist_next = last_dist_reg;
        if (s4_reg.over) begin
            dist_next = last_dist_reg;
        end else begin
            dist_next = lin_dist;
        end
        if (en_out && v4_reg && !s4_reg.over) begin
            last_dist_next = lin_dist;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            m_valid_reg   <= 1'b0;
            last_dist_reg <= '0;
        end else begin
            if (en2) begin
                v2_reg <= win.valid;
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
            if (en4) begin
                v4_reg <= v3_reg;
            end
            if (en_out) begin
                m_valid_reg <= v4_reg;
            end
            last_dist_reg <= last_dist_next;
        end
    end

    // Payload registers advance with their valids
    always_ff @(posedge aclk) begin
        if (en2 && win.valid) begin
            mean_reg <= mean_prod[MEAN_SH +: MEAN_W];
        end
        if (en3 && v2_reg) begin
            s3_reg <= s3_next;
        end
        if (en4 && v3_reg) begin
            s4_reg <= s4_next;
        end
        if (en_out && v4_reg) begin
            dist_reg     <= dist_next;
            mean_out_reg <= s4_reg.mean;
            held_reg     <= s4_reg.over;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {7'd0, mean_out_reg, dist_reg};
    assign m_tuser[0] = held_reg;

endmodule

### rtl/core/adl_checker.sv
// ============================================================================
// adl_checker
// Port-level checks on the result stream of the distance linearizer.
// ============================================================================
`include "adc_average_distance_linearizer_macros.svh"

module adl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [0:0]  m_tuser
);

    logic [6:0] dist_cm;
    logic [9:0] mean;
    logic       held;
    logic       in_idle;

    assign dist_cm = m_tdata[6:0];
    assign mean    = m_tdata[16:7];
    assign held    = m_tuser[0];
    assign in_idle = !s_tvalid && (s_tdata == s_tdata);

    `ADL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
    `ADL_ASSERT_NOW(a_held_flag, m_tvalid, held == (mean > 10'd490), "held flag disagrees with mean")
    `ADL_ASSERT_NOW(a_low_mean, m_tvalid && !held && mean <= 10'd80, dist_cm == 7'd80, "low mean must give 80 cm")
    `ADL_ASSERT_NOW(a_dist_range, m_tvalid && !held, dist_cm >= 7'd10 && dist_cm <= 7'd80, "distance outside table range")
    `ADL_ASSERT_NEXT(a_ready_free, in_idle && !m_tvalid, s_tready, "input stalled with empty output")

endmodule

bind adc_average_distance_linearizer adl_checker u_adl_checker (.*);

### dv/tb.sv
// ============================================================================
// tb
// Self-checking bench for the averaging distance linearizer. It streams 10-bit
// converter samples into the block and predicts one reading per window of
// SAMPLES samples: the truncated mean and its distance from the piecewise
// linear table, or the held distance above the top knot. It runs a directed
// walk over the knots and extremes, then random windows aimed across the
// table, with random idling on both sides and one long output hold-off.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import adl_pkg::*;

    localparam int RUN_LIMIT      = 100000;  // cycles before the run is declared hung
    localparam int RANDOM_SAMPLES = 1140;
    localparam int IDLE_PCT       = 32;
    localparam int HOLDOFF_CYCLES = 600;     // long enough to fill every stage
    localparam int DRAIN_CYCLES   = 16;
    localparam int HOLDOFF_WINDOW = 8;       // random window that starts the hold-off
    localparam int QUIET_FIRST    = 30;      // random windows with no idling at all
    localparam int QUIET_LAST     = 45;

    // One reading of the result channel
    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [MEAN_W-1:0] mean;
        logic              held;
    } reading_t;

    // One directed row: a window of SAMPLES copies of one sample value, so the
    // mean equals the value. Typed rows carry their reading.
    typedef struct packed {
        logic                typed;
        logic [SAMPLE_W-1:0] sample;
        logic [DIST_W-1:0]   distance;
        logic                held;
    } window_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;     // [9:0] adc_sample, [15:10] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;           // [6:0] distance_cm, [16:7] mean_value, [23:17] zero
    logic [0:0]  m_tuser;           // [0] held

    // Shadow state of the averaging window
    logic [SUM_W-1:0]  window_sum     = '0;
    int                window_count   = 0;
    logic [DIST_W-1:0] kept_distance  = '0;

    reading_t    pending_readings [$];
    window_row_t directed_rows [$];
    reading_t    want;
    int          errors          = 0;
    int          cycle_count     = 0;
    bit          quiet           = 1'b0;
    int          holdoff_requests = 0;
    int          holdoff_served  = 0;
    int          holdoff_left    = 0;

    adc_average_distance_linearizer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Map a mean at or below the top knot to centimeters.
    function automatic logic [DIST_W-1:0] distance_of(input logic [MEAN_W-1:0] mean);
        int unsigned knot;
        int unsigned base;
        int unsigned slope;
        int unsigned delta;
        if (mean <= LOW_KNOT) return LOW_DIST;
        if (mean == TOP_KNOT) return TOP_DIST;
        // slope in hundredths of a mean step per centimeter; 0 means halve
        if (mean >= 276)      begin knot = 276; base = 20; slope = 2377; end
        else if (mean >= 196) begin knot = 196; base = 30; slope = 888;  end
        else if (mean >= 150) begin knot = 150; base = 40; slope = 511;  end
        else if (mean >= 124) begin knot = 124; base = 50; slope = 288;  end
        else if (mean >= 106) begin knot = 106; base = 60; slope = 0;    end
        else if (mean >= 87)  begin knot = 87;  base = 70; slope = 211;  end
        else                  begin knot = 80;  base = 80; slope = 77;   end
        delta = mean - knot;
        if (slope == 0) return DIST_W'(base - delta / 2);
        return DIST_W'((base * slope - 100 * delta) / slope);
    endfunction

    // Accumulate one sample; return 1 with the reading when the window closes.
    function automatic bit window_step(input logic [SAMPLE_W-1:0] sample,
                                       output reading_t reading);
        logic [MEAN_W-1:0] mean;
        reading = '0;
        window_sum = SUM_W'(window_sum + sample);
        if (window_count + 1 < SAMPLES) begin
            window_count++;
            return 1'b0;
        end
        mean = MEAN_W'(window_sum / SAMPLES);
        window_sum = '0;
        window_count = 0;
        if (mean > TOP_KNOT) begin
            reading.held = 1'b1;
        end else begin
            kept_distance = distance_of(mean);
        end
        reading.distance = kept_distance;
        reading.mean = mean;
        return 1'b1;
    endfunction

    // Offer one sample, wait for its transaction, then advance the prediction.
    task automatic offer_sample(input logic [SAMPLE_W-1:0] sample,
                                output bit closed, output reading_t reading);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, sample};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        closed = window_step(sample, reading);
    endtask

    // Check result transactions and drive m_tready. Sample on the edge, so the
    // values seen are the ones that were stable before it.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_readings.size() == 0) begin
                $display("%0t: unexpected reading distance=%0d mean=%0d held=%0d",
                         $realtime, m_tdata[6:0], m_tdata[16:7], m_tuser[0]);
                errors++;
            end else begin
                want = pending_readings.pop_front();
                if (m_tdata[6:0] !== want.distance) begin
                    $display("%0t: distance_cm expected %0d actual %0d",
                             $realtime, want.distance, m_tdata[6:0]);
                    errors++;
                end
                if (m_tdata[16:7] !== want.mean) begin
                    $display("%0t: mean_value expected %0d actual %0d",
                             $realtime, want.mean, m_tdata[16:7]);
                    errors++;
                end
                if (m_tuser[0] !== want.held) begin
                    $display("%0t: held expected %0d actual %0d",
                             $realtime, want.held, m_tuser[0]);
                    errors++;
                end
            end
        end
        // Start the long hold-off when the sender asks for it
        if (holdoff_served != holdoff_requests) begin
            holdoff_served = holdoff_requests;
            holdoff_left = HOLDOFF_CYCLES;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("adc_average_distance_linearizer verification failed");
            $finish;
        end
    end

    initial begin
        bit          closed;
        reading_t    reading;
        window_row_t row;
        int          sent;
        int          win;
        int          mode;
        int          target;
        int          value;
        logic [SAMPLE_W-1:0] sample;

        // Knots, neighbors of knots and both extremes of the sample range.
        // The first row runs above the top knot right after reset, so it holds
        // the reset distance of zero.
        directed_rows = '{
            '{1'b1, 10'd1023, 7'd0,  1'b1},
            '{1'b1, 10'd0,    7'd80, 1'b0},
            '{1'b1, 10'd80,   7'd80, 1'b0},
            '{1'b0, 10'd81,   7'd0,  1'b0},
            '{1'b0, 10'd86,   7'd0,  1'b0},
            '{1'b0, 10'd87,   7'd0,  1'b0},
            '{1'b0, 10'd88,   7'd0,  1'b0},
            '{1'b0, 10'd105,  7'd0,  1'b0},
            '{1'b0, 10'd106,  7'd0,  1'b0},
            '{1'b0, 10'd107,  7'd0,  1'b0},
            '{1'b0, 10'd108,  7'd0,  1'b0},
            '{1'b0, 10'd123,  7'd0,  1'b0},
            '{1'b0, 10'd124,  7'd0,  1'b0},
            '{1'b0, 10'd149,  7'd0,  1'b0},
            '{1'b0, 10'd150,  7'd0,  1'b0},
            '{1'b0, 10'd195,  7'd0,  1'b0},
            '{1'b0, 10'd196,  7'd0,  1'b0},
            '{1'b0, 10'd275,  7'd0,  1'b0},
            '{1'b0, 10'd276,  7'd0,  1'b0},
            '{1'b0, 10'd489,  7'd0,  1'b0},
            '{1'b1, 10'd490,  7'd10, 1'b0},
            '{1'b1, 10'd1023, 7'd10, 1'b1},
            '{1'b1, 10'd491,  7'd10, 1'b1}
        };

        // Hold reset, then release it on an edge
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            for (int n = 0; n < SAMPLES; n++) begin
                offer_sample(row.sample, closed, reading);
                if (closed) begin
                    if (row.typed)
                        pending_readings.push_back('{row.distance, row.sample, row.held});
                    else
                        pending_readings.push_back(reading);
                end
            end
        end

        // Random windows: mostly aimed at a target mean across the table, some
        // uniform noise and some windows of samples drawn from the two extremes.
        sent = 0;
        win = 0;
        while (sent < RANDOM_SAMPLES) begin
            quiet = (win >= QUIET_FIRST && win < QUIET_LAST);
            if (win == HOLDOFF_WINDOW) holdoff_requests++;
            mode = $urandom_range(9);
            if (mode <= 5) target = $urandom_range(520, 60);
            else target = $urandom_range(1023);
            for (int n = 0; n < SAMPLES; n++) begin
                if (mode <= 5 || mode == 9) begin
                    value = target + int'($urandom_range(16)) - 8;
                    if (value < 0) value = 0;
                    if (value > 1023) value = 1023;
                    sample = SAMPLE_W'(value);
                end else if (mode <= 7) begin
                    sample = SAMPLE_W'($urandom_range(1023));
                end else begin
                    sample = $urandom_range(1) ? 10'h3FF : 10'h000;
                end
                offer_sample(sample, closed, reading);
                if (closed) pending_readings.push_back(reading);
                sent++;
            end
            win++;
        end
        quiet = 1'b0;
        s_tvalid <= 1'b0;

        // Drain, then watch a little longer for stray readings
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0)
            $display("adc_average_distance_linearizer verification clean");
        else
            $display("adc_average_distance_linearizer verification failed");
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/adl_pkg.sv
rtl/core/adl_accum.sv
rtl/core/adc_average_distance_linearizer.sv
rtl/core/adl_checker.sv
dv/tb.sv
